/* rtl/core/tbli_pkg.sv */
`default_nettype none

package tbli_pkg;

  // Opcodes
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_INTERP = 2'd1;
  localparam logic [1:0] OP_RUN    = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZSPAN = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_SAT   = 2'd3;

  // Column codes
  localparam logic [1:0] COL_A = 2'd0;
  localparam logic [1:0] COL_B = 2'd1;
  localparam logic [1:0] COL_C = 2'd2;

  localparam int RowBits  = 96;
  localparam int DivSteps = 35;   // quotient bits below the overflow limit

  typedef struct packed {
    logic        [1:0]  opcode;
    logic        [1:0]  table_sel;
    logic        [5:0]  row_index;
    logic               last_row;
    logic signed [31:0] col_a;
    logic signed [31:0] col_b;
    logic signed [31:0] col_c;
    logic signed [31:0] query_key;
    logic        [1:0]  search_col;
    logic        [1:0]  result_col;
  } req_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic        [1:0]  status;
    logic        [5:0]  bracket_row;
  } res_t;

  // Read address source
  typedef enum logic [1:0] {
    RD_MID,
    RD_A,
    RD_B,
    RD_RUN
  } rd_src_e;

  // Result selection at emit
  typedef enum logic [2:0] {
    RES_WRITE,
    RES_NOP,
    RES_EMPTY,
    RES_RUN,
    RES_ZERO,
    RES_INTERP
  } res_sel_e;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     wr;
    logic     rd;
    rd_src_e  rd_src;
    logic     bis_upd;
    logic     cap_a;
    logic     cap_b;
    logic     run_init;
    logic     run_upd;
    logic     sub;
    logic     mul;
    logic     div_init;
    logic     div_step;
    logic     emit;
    res_sel_e res_sel;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [1:0] op;
    logic       empty;
    logic       bis_done;
    logic       run_done;
    logic       span_zero;
    logic       div_ovf;
    logic       div_last;
  } sts_t;

  // Column 3 acts as column 2
  function automatic logic signed [31:0] col_pick(input logic [RowBits-1:0] row,
                                                  input logic [1:0] sel);
    logic signed [31:0] v;
    begin
      case (sel)
        COL_A:   v = row[31:0];
        COL_B:   v = row[63:32];
        default: v = row[95:64];
      endcase
      return v;
    end
  endfunction

  // Magnitude of a 33-bit signed value
  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    begin
      return v[32] ? 33'(-v) : 33'(v);
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/tbli_ram.sv */
`default_nettype none

module tbli_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/tbli_ctrl.sv */
`default_nettype none

module tbli_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  wire tbli_pkg::sts_t sts_i,
  output tbli_pkg::cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_BIS_CHK,
    S_BIS_USE,
    S_A_USE,
    S_B_USE,
    S_SUB,
    S_MUL,
    S_DINIT,
    S_DIV,
    S_FIN,
    S_RUN_INIT,
    S_RUN_CHK,
    S_RUN_USE
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_src  = tbli_pkg::RD_A;
    cmd_o.res_sel = tbli_pkg::RES_NOP;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.op == tbli_pkg::OP_WRITE) begin
          cmd_o.wr      = 1'b1;
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = tbli_pkg::RES_WRITE;
          state_d       = S_IDLE;
        end else if (sts_i.op == tbli_pkg::OP_NONE) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = tbli_pkg::RES_NOP;
          state_d       = S_IDLE;
        end else if (sts_i.empty) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = tbli_pkg::RES_EMPTY;
          state_d       = S_IDLE;
        end else if (sts_i.op == tbli_pkg::OP_RUN) begin
          // b holds the last row here
          cmd_o.rd     = 1'b1;
          cmd_o.rd_src = tbli_pkg::RD_B;
          state_d      = S_RUN_INIT;
        end else begin
          state_d = S_BIS_CHK;
        end
      end
      S_BIS_CHK: begin
        cmd_o.rd = 1'b1;
        if (sts_i.bis_done) begin
          cmd_o.rd_src = tbli_pkg::RD_A;
          state_d      = S_A_USE;
        end else begin
          cmd_o.rd_src = tbli_pkg::RD_MID;
          state_d      = S_BIS_USE;
        end
      end
      S_BIS_USE: begin
        cmd_o.bis_upd = 1'b1;
        state_d       = S_BIS_CHK;
      end
      S_A_USE: begin
        cmd_o.cap_a  = 1'b1;
        cmd_o.rd     = 1'b1;
        cmd_o.rd_src = tbli_pkg::RD_B;
        state_d      = S_B_USE;
      end
      S_B_USE: begin
        cmd_o.cap_b = 1'b1;
        state_d     = S_SUB;
      end
      S_SUB: begin
        cmd_o.sub = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DINIT;
      end
      S_DINIT: begin
        if (sts_i.span_zero) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = tbli_pkg::RES_ZERO;
          state_d       = S_IDLE;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        if (sts_i.div_ovf) begin
          state_d = S_FIN;
        end else begin
          cmd_o.div_step = 1'b1;
          if (sts_i.div_last) begin
            state_d = S_FIN;
          end
        end
      end
      S_FIN: begin
        cmd_o.emit    = 1'b1;
        cmd_o.res_sel = tbli_pkg::RES_INTERP;
        state_d       = S_IDLE;
      end
      S_RUN_INIT: begin
        cmd_o.run_init = 1'b1;
        state_d        = S_RUN_CHK;
      end
      S_RUN_CHK: begin
        if (sts_i.run_done) begin
          cmd_o.emit    = 1'b1;
          cmd_o.res_sel = tbli_pkg::RES_RUN;
          state_d       = S_IDLE;
        end else begin
          cmd_o.rd     = 1'b1;
          cmd_o.rd_src = tbli_pkg::RD_RUN;
          state_d      = S_RUN_USE;
        end
      end
      S_RUN_USE: begin
        cmd_o.run_upd = 1'b1;
        state_d       = S_RUN_CHK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // An accepted request always leaves idle
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not make the block busy");

  // Every emit returns the controller to idle
  a_emit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> !busy_o)
    else $error("controller stayed busy after emit");

endmodule

`default_nettype wire

/* rtl/core/tbli_dpath.sv */
`default_nettype none

module tbli_dpath #(
  parameter int NUM_TABLES = 4,
  parameter int MAX_ROWS   = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire tbli_pkg::req_t req_i,
  input  wire tbli_pkg::cmd_t cmd_i,
  output tbli_pkg::sts_t      sts_o,
  output logic                done_o,
  output tbli_pkg::res_t      res_o
);

  localparam int Depth = NUM_TABLES * MAX_ROWS;
  localparam int AW    = $clog2(Depth);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int LW    = $clog2(MAX_ROWS + 1);

  // Request fields held for the item's duration
  logic [1:0]                   op_q, t_q, sc_q, rc_q;
  logic [5:0]                   ri_q;
  logic                         last_row_q;
  logic signed [31:0]           q_q;
  logic [tbli_pkg::RowBits-1:0] wrow_q;
  logic                         empty_q;

  logic [LW-1:0] len_q [NUM_TABLES];
  logic [LW-1:0] n_sel;
  logic          t_ok;

  // Search state
  logic [RW-1:0] a_q, b_q, r_q;
  logic [RW:0]   mid_sum;
  logic [RW-1:0] mid;

  // Captured rows and arithmetic
  logic signed [31:0] ka_q, ya_q, kb_q, yb_q, last_q, y_q;
  logic               miss_q;
  logic signed [32:0] span_q, dy_q, dk_q;
  logic [65:0]        m_q;
  logic [32:0]        s_q;
  logic               neg_q, szero_q;

  // Divider
  logic [tbli_pkg::DivSteps-1:0] num_q, quot_q;
  logic [32:0]                   rem_q, rem2;
  logic [5:0]                    cnt_q;
  logic                          ovf_q;
  logic [65:0]                   num_full;

  // Memory interface
  logic                         we, wr_ok;
  logic [AW-1:0]                waddr, raddr;
  logic [RW-1:0]                rrow;
  logic [tbli_pkg::RowBits-1:0] rdata;
  logic signed [31:0]           rd_k, rd_y;

  logic           done_q;
  tbli_pkg::res_t res_q, res_d;

  // Selected table length
  always_comb begin
    n_sel = '0;
    for (int i = 0; i < NUM_TABLES; i++) begin
      if (int'(req_i.table_sel) == i) begin
        n_sel = len_q[i];
      end
    end
  end
  assign t_ok = (int'(req_i.table_sel) < NUM_TABLES);

  assign mid_sum = {1'b0, a_q} + {1'b0, b_q};
  assign mid     = mid_sum[RW:1];

  // Read address mux
  always_comb begin
    case (cmd_i.rd_src)
      tbli_pkg::RD_MID: rrow = mid;
      tbli_pkg::RD_A:   rrow = a_q;
      tbli_pkg::RD_B:   rrow = b_q;
      default:          rrow = r_q - RW'(1);
    endcase
  end
  assign raddr = AW'(int'(t_q) * MAX_ROWS + int'(rrow));

  assign wr_ok = (int'(t_q) < NUM_TABLES) && (int'(ri_q) < MAX_ROWS);
  assign we    = cmd_i.wr && wr_ok;
  assign waddr = AW'(int'(t_q) * MAX_ROWS + int'(ri_q));

  tbli_ram #(
    .WIDTH (tbli_pkg::RowBits),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wrow_q),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign rd_k = tbli_pkg::col_pick(rdata, sc_q);
  assign rd_y = tbli_pkg::col_pick(rdata, rc_q);

  // Table lengths, cleared on reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TABLES; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_TABLES; i++) begin
        if (we && last_row_q && int'(t_q) == i) begin
          len_q[i] <= LW'(int'(ri_q) + 1);
        end
      end
    end
  end

  assign num_full = m_q + 66'(s_q >> 1);
  assign rem2     = {rem_q[31:0], num_q[tbli_pkg::DivSteps-1]};

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q       <= req_i.opcode;
      t_q        <= req_i.table_sel;
      ri_q       <= req_i.row_index;
      last_row_q <= req_i.last_row;
      q_q        <= req_i.query_key;
      sc_q       <= (req_i.search_col == 2'd3) ? tbli_pkg::COL_C : req_i.search_col;
      rc_q       <= (req_i.result_col == 2'd3) ? tbli_pkg::COL_C : req_i.result_col;
      wrow_q     <= {req_i.col_c, req_i.col_b, req_i.col_a};
      empty_q    <= !t_ok || (n_sel == '0);
      a_q        <= '0;
      b_q        <= RW'(n_sel - LW'(1));
      r_q        <= RW'(n_sel - LW'(1));
    end
    // Bisection step: a moves while the row key is not above the query
    if (cmd_i.bis_upd) begin
      if (rd_k > q_q) begin
        b_q <= mid;
      end else begin
        a_q <= mid;
      end
    end
    if (cmd_i.cap_a) begin
      ka_q <= rd_k;
      ya_q <= rd_y;
    end
    if (cmd_i.cap_b) begin
      kb_q <= rd_k;
      yb_q <= rd_y;
    end
    // Trailing run walk
    if (cmd_i.run_init) begin
      last_q <= rd_k;
      y_q    <= rd_y;
      miss_q <= 1'b0;
    end
    if (cmd_i.run_upd) begin
      if (rd_k == last_q) begin
        r_q <= r_q - RW'(1);
        y_q <= rd_y;
      end else begin
        miss_q <= 1'b1;
      end
    end
    // Differences
    if (cmd_i.sub) begin
      span_q <= $signed({kb_q[31], kb_q}) - $signed({ka_q[31], ka_q});
      dy_q   <= $signed({yb_q[31], yb_q}) - $signed({ya_q[31], ya_q});
      dk_q   <= $signed({q_q[31], q_q}) - $signed({ka_q[31], ka_q});
    end
    // Product of magnitudes and sign of the ratio
    if (cmd_i.mul) begin
      m_q     <= 66'(tbli_pkg::mag33(dy_q)) * 66'(tbli_pkg::mag33(dk_q));
      s_q     <= tbli_pkg::mag33(span_q);
      szero_q <= (span_q == '0);
      neg_q   <= ((dy_q[32] != dk_q[32]) != span_q[32]) && (dy_q != '0) && (dk_q != '0);
    end
    // Rounded division, one quotient bit a cycle; big upper part means overflow
    if (cmd_i.div_init) begin
      rem_q  <= 33'(num_full[65:tbli_pkg::DivSteps]);
      ovf_q  <= (33'(num_full[65:tbli_pkg::DivSteps]) >= s_q);
      num_q  <= num_full[tbli_pkg::DivSteps-1:0];
      quot_q <= '0;
      cnt_q  <= 6'(tbli_pkg::DivSteps - 1);
    end
    if (cmd_i.div_step) begin
      if (rem2 >= s_q) begin
        rem_q  <= rem2 - s_q;
        quot_q <= {quot_q[tbli_pkg::DivSteps-2:0], 1'b1};
      end else begin
        rem_q  <= rem2;
        quot_q <= {quot_q[tbli_pkg::DivSteps-2:0], 1'b0};
      end
      num_q <= {num_q[tbli_pkg::DivSteps-2:0], 1'b0};
      cnt_q <= cnt_q - 6'd1;
    end
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
  end

  // Result formation
  always_comb begin
    logic signed [36:0] v;
    logic               sat;
    v   = '0;
    sat = 1'b0;
    res_d = '0;
    case (cmd_i.res_sel)
      tbli_pkg::RES_WRITE: begin
        res_d.bracket_row = ri_q;
      end
      tbli_pkg::RES_EMPTY: begin
        res_d.status = tbli_pkg::ST_EMPTY;
      end
      tbli_pkg::RES_RUN: begin
        res_d.result_value = y_q;
        res_d.bracket_row  = 6'(int'(r_q));
      end
      tbli_pkg::RES_ZERO: begin
        res_d.result_value = ya_q;
        res_d.status       = tbli_pkg::ST_ZSPAN;
        res_d.bracket_row  = 6'(int'(a_q));
      end
      tbli_pkg::RES_INTERP: begin
        res_d.bracket_row = 6'(int'(a_q));
        sat = ovf_q || (quot_q > 35'h4_0000_0000);
        if (neg_q) begin
          v = $signed({{5{ya_q[31]}}, ya_q}) - $signed({2'b00, quot_q});
        end else begin
          v = $signed({{5{ya_q[31]}}, ya_q}) + $signed({2'b00, quot_q});
        end
        if (sat) begin
          res_d.status       = tbli_pkg::ST_SAT;
          res_d.result_value = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else if (v > 37'sd2147483647) begin
          res_d.status       = tbli_pkg::ST_SAT;
          res_d.result_value = 32'sh7FFF_FFFF;
        end else if (v < -37'sd2147483648) begin
          res_d.status       = tbli_pkg::ST_SAT;
          res_d.result_value = 32'sh8000_0000;
        end else begin
          res_d.result_value = v[31:0];
        end
      end
      default: begin
        res_d = '0;
      end
    endcase
  end

  // Result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

  // Status toward the controller
  assign sts_o.op        = op_q;
  assign sts_o.empty     = empty_q;
  assign sts_o.bis_done  = ((int'(b_q) - int'(a_q)) <= 1);
  assign sts_o.run_done  = miss_q || (r_q == '0);
  assign sts_o.span_zero = szero_q;
  assign sts_o.div_ovf   = ovf_q;
  assign sts_o.div_last  = (cnt_q == 6'd0);

  // Bisection keeps the lower row strictly below the upper row
  a_bis_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.bis_upd |=> (a_q < b_q))
    else $error("bisection lost bracket order");

  // Run walk only moves down from a nonzero row
  a_run_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.run_upd && !miss_q) |-> (r_q != '0))
    else $error("run walk stepped below row zero");

endmodule

`default_nettype wire

/* rtl/core/table_bisect_linear_interp.sv */
`default_nettype none

// Channel   Direction  Handshake                    Payload
// request   in         start_i, accepted when !busy_o  req_i  (tbli_pkg::req_t)
// result    out        done_o, one-cycle strobe         res_o  (tbli_pkg::res_t)
//
// One request at a time. A write or empty/no-op request is answered at decode.
// An interpolation bisects with one read per step through the single read port
// of the row memory, captures the bracketing rows, forms differences and a
// product, then runs a restoring divider producing one quotient bit a cycle.
// A run query reads earlier rows one at a time, walking back from the last row.
// Reset clears the table lengths; row contents are undefined until written.
// The result appears the cycle after the last state and cannot be held off.

module table_bisect_linear_interp #(
  parameter int NUM_TABLES = 4,
  parameter int MAX_ROWS   = 64
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire tbli_pkg::req_t req_i,
  output logic                done_o,
  output tbli_pkg::res_t      res_o
);

  tbli_pkg::cmd_t cmd;
  tbli_pkg::sts_t sts;

  tbli_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  tbli_dpath #(
    .NUM_TABLES (NUM_TABLES),
    .MAX_ROWS   (MAX_ROWS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .done_o (done_o),
    .res_o  (res_o)
  );

endmodule

`default_nettype wire

/* tb/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NTAB = 4;
  localparam int NROW = 64;

  // Row tables as the block should hold them, plus the queue of expected results
  class interp_scoreboard;
    logic signed [31:0] rows [NTAB][NROW][3];
    int unsigned        len [NTAB];
    tbli_pkg::res_t     pending [$];
    int                 errors;

    function new();
      errors = 0;
      for (int t = 0; t < NTAB; t++) len[t] = 0;
    endfunction

    // Column select three reads column two
    function logic signed [31:0] cell_val(int t, int r, logic [1:0] sel);
      return rows[t][r][(sel > 2'd2) ? 2 : int'(sel)];
    endfunction

    function tbli_pkg::res_t predict(tbli_pkg::req_t q);
      tbli_pkg::res_t      o;
      int unsigned         n, a, b, r, base_t;
      longint              ka, kb, ya, yb, span, dy, dk, val;
      longint unsigned     m, s, qm;
      logic signed [31:0]  last;
      bit                  neg;
      o = '0;
      base_t = q.table_sel;
      if (q.opcode == tbli_pkg::OP_WRITE) begin
        rows[base_t][q.row_index][0] = q.col_a;
        rows[base_t][q.row_index][1] = q.col_b;
        rows[base_t][q.row_index][2] = q.col_c;
        if (q.last_row) len[base_t] = q.row_index + 1;
        o.bracket_row = q.row_index;
        return o;
      end
      if (q.opcode == tbli_pkg::OP_NONE) return o;
      n = len[base_t];
      if (n == 0) begin
        o.status = tbli_pkg::ST_EMPTY;
        return o;
      end
      // run query: walk back over the trailing equal keys
      if (q.opcode == tbli_pkg::OP_RUN) begin
        last = cell_val(base_t, n - 1, q.search_col);
        r = n - 1;
        while (r > 0 && cell_val(base_t, r - 1, q.search_col) == last) r--;
        o.result_value = cell_val(base_t, r, q.result_col);
        o.bracket_row = r[5:0];
        return o;
      end
      // bisection for the bracketing rows
      a = 0;
      b = n - 1;
      while (b - a > 1) begin
        r = (a + b) / 2;
        if (cell_val(base_t, r, q.search_col) > q.query_key) b = r;
        else a = r;
      end
      ka = cell_val(base_t, a, q.search_col);
      kb = cell_val(base_t, b, q.search_col);
      ya = cell_val(base_t, a, q.result_col);
      yb = cell_val(base_t, b, q.result_col);
      o.bracket_row = a[5:0];
      span = kb - ka;
      dy = yb - ya;
      dk = longint'(q.query_key) - ka;
      if (span == 0) begin
        o.result_value = ya[31:0];
        o.status = tbli_pkg::ST_ZSPAN;
        return o;
      end
      neg = ((dy < 0) != (dk < 0)) != (span < 0);
      if (dy == 0 || dk == 0) neg = 0;
      m = longint'(dy < 0 ? -dy : dy) * longint'(dk < 0 ? -dk : dk);
      s = (span < 0) ? -span : span;
      qm = (m + s / 2) / s;
      if (qm > (64'd1 << 34)) begin
        o.result_value = neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        o.status = tbli_pkg::ST_SAT;
        return o;
      end
      val = neg ? ya - longint'(qm) : ya + longint'(qm);
      if (val > 64'sh7fff_ffff) begin
        o.result_value = 32'sh7fff_ffff;
        o.status = tbli_pkg::ST_SAT;
      end else if (val < -64'sh8000_0000) begin
        o.result_value = 32'sh8000_0000;
        o.status = tbli_pkg::ST_SAT;
      end else begin
        o.result_value = val[31:0];
      end
      return o;
    endfunction

    function void note_request(tbli_pkg::req_t q);
      pending.push_back(predict(q));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(tbli_pkg::res_t got);
      tbli_pkg::res_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.result_value, 32'd0);
        return;
      end
      want = pending.pop_front();
      if (got.result_value !== want.result_value)
        report("result_value", got.result_value, want.result_value);
      if (got.status !== want.status)
        report("status", 32'(got.status), 32'(want.status));
      if (got.bracket_row !== want.bracket_row)
        report("bracket_row", 32'(got.bracket_row), 32'(want.bracket_row));
    endtask
  endclass

  logic clk_i, rst_ni, start_i, busy_o, done_o;
  tbli_pkg::req_t req_i;
  tbli_pkg::res_t res_o;

  interp_scoreboard sb;
  logic [63:0] written [NTAB];
  logic [1:0]  key_col [NTAB];
  int          sent;

  table_bisect_linear_interp dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .done_o, .res_o
  );

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // results cannot be held off, so every strobe is checked
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res_o);
  end

  // gap between requests: mostly none or short, a few long
  function int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task send(tbli_pkg::req_t q);
    int gap;
    start_i <= 1'b1;
    req_i <= q;
    do @(posedge clk_i); while (busy_o);
    sb.note_request(q);
    sent++;
    if (q.opcode == tbli_pkg::OP_WRITE) written[q.table_sel][q.row_index] = 1'b1;
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // a query only goes to a table whose rows in use were all loaded
  function bit table_ok(int t);
    for (int r = 0; r < sb.len[t]; r++) if (!written[t][r]) return 0;
    return 1;
  endfunction

  function tbli_pkg::req_t rand_req(logic [1:0] op, logic [1:0] t);
    tbli_pkg::req_t q;
    logic [159:0]   rnd;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
    q = rnd[$bits(tbli_pkg::req_t)-1:0];
    q.opcode = op;
    q.table_sel = t;
    q.last_row = 1'b0;
    q.search_col = 2'($urandom_range(3));
    q.result_col = 2'($urandom_range(3));
    return q;
  endfunction

  task write_row(int t, int r, bit last, logic signed [31:0] a,
                 logic signed [31:0] b, logic signed [31:0] c);
    tbli_pkg::req_t q;
    q = rand_req(tbli_pkg::OP_WRITE, 2'(t));
    q.row_index = 6'(r);
    q.last_row = last;
    q.col_a = a;
    q.col_b = b;
    q.col_c = c;
    send(q);
  endtask

  task query(logic [1:0] op, int t, logic signed [31:0] key, logic [1:0] sc, logic [1:0] rc);
    tbli_pkg::req_t q;
    q = rand_req(op, 2'(t));
    q.query_key = key;
    q.search_col = sc;
    q.result_col = rc;
    send(q);
  endtask

  // load a table with one column sorted ascending, sometimes with repeats
  task load_table(int t, int n);
    logic signed [31:0] keys [$];
    logic signed [31:0] v [3];
    int  sc, mode;
    mode = $urandom_range(3);
    sc = $urandom_range(2);
    keys = {};
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: keys.push_back($urandom);
        1: keys.push_back($signed($urandom_range(6)) - 3);
        default: keys.push_back($signed($urandom_range(200000)) - 100000);
      endcase
    end
    keys.sort();
    if ($urandom_range(5) == 0)
      for (int i = $urandom_range(n - 1); i < n; i++) keys[i] = keys[n - 1];
    key_col[t] = 2'(sc);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < 3; c++)
        v[c] = ($urandom_range(1)) ? $urandom : $signed($urandom_range(400000)) - 200000;
      v[sc] = keys[r];
      write_row(t, r, (r == n - 1) || ($urandom_range(9) == 0), v[0], v[1], v[2]);
    end
  endtask

  task rand_query(int t);
    logic signed [31:0] key;
    int n, p;
    n = sb.len[t];
    p = $urandom_range(9);
    if (n > 0 && p < 4)
      key = sb.rows[t][$urandom_range(n - 1)][key_col[t]] + $signed($urandom_range(4)) - 2;
    else if (p < 7)
      key = $signed($urandom_range(400000)) - 200000;
    else
      key = $urandom;
    query(($urandom_range(3) == 0) ? tbli_pkg::OP_RUN : tbli_pkg::OP_INTERP, t, key,
          ($urandom_range(6) == 0) ? 2'($urandom_range(3)) : key_col[t],
          2'($urandom_range(3)));
  endtask

  initial begin
    int t, n;
    sb = new();
    sent = 0;
    for (int i = 0; i < NTAB; i++) begin
      written[i] = '0;
      key_col[i] = tbli_pkg::COL_A;
    end
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty tables, unused opcode
    query(tbli_pkg::OP_INTERP, 0, 0, tbli_pkg::COL_A, tbli_pkg::COL_B);
    query(tbli_pkg::OP_RUN, 3, 0, tbli_pkg::COL_A, tbli_pkg::COL_B);
    query(tbli_pkg::OP_NONE, 1, 32'sh7fff_ffff, 2'd3, 2'd3);
    // single row: zero span, run stops at row 0
    write_row(0, 0, 1, 32'sh8000_0000, 32'sh7fff_ffff, -1);
    query(tbli_pkg::OP_INTERP, 0, 32'sh7fff_ffff, tbli_pkg::COL_A, tbli_pkg::COL_B);
    query(tbli_pkg::OP_RUN, 0, 0, tbli_pkg::COL_A, 2'd3);
    // two rows with extreme slope: saturation both ways
    write_row(1, 0, 0, 0, 0, 32'sh7fff_ffff);
    write_row(1, 1, 1, 1, 32'sh7fff_ffff, 32'sh8000_0000);
    query(tbli_pkg::OP_INTERP, 1, 32'sh7fff_ffff, tbli_pkg::COL_A, tbli_pkg::COL_B);
    query(tbli_pkg::OP_INTERP, 1, 32'sh8000_0000, tbli_pkg::COL_A, tbli_pkg::COL_B);
    query(tbli_pkg::OP_INTERP, 1, 32'sh7fff_ffff, tbli_pkg::COL_A, 2'd3);
    query(tbli_pkg::OP_INTERP, 1, 0, tbli_pkg::COL_A, tbli_pkg::COL_C);
    // all rows equal in the search column
    for (int r = 0; r < 4; r++) write_row(2, r, r == 3, 5, r * 65536, -r);
    query(tbli_pkg::OP_RUN, 2, 0, tbli_pkg::COL_A, tbli_pkg::COL_B);
    query(tbli_pkg::OP_INTERP, 2, 5, tbli_pkg::COL_A, tbli_pkg::COL_C);
    // full 64-row table in the top table and row index
    load_table(3, NROW);
    query(tbli_pkg::OP_INTERP, 3, 32'sh8000_0000, key_col[3], tbli_pkg::COL_B);
    query(tbli_pkg::OP_RUN, 3, 32'sh7fff_ffff, key_col[3], tbli_pkg::COL_C);

    // random: mostly loaded tables with queries, some noise
    while (sent < 700) begin
      t = $urandom_range(NTAB - 1);
      case ($urandom_range(9))
        0, 1, 2: begin
          n = ($urandom_range(19) == 0) ? NROW : $urandom_range(1, 8);
          load_table(t, n);
        end
        3: begin
          if ($urandom_range(1)) query(tbli_pkg::OP_NONE, t, $urandom,
                                       2'($urandom_range(3)), 2'($urandom_range(3)));
          else if (table_ok(t)) rand_query(t);
        end
        default: begin
          repeat ($urandom_range(2, 8)) begin
            t = $urandom_range(NTAB - 1);
            if (table_ok(t)) rand_query(t);
          end
        end
      endcase
    end
    start_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS table_bisect_linear_interp");
    end else begin
      $display("FAIL table_bisect_linear_interp");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("FAIL table_bisect_linear_interp");
    $finish;
  end

endmodule

`default_nettype wire
